### design/md5_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_pkg: shared types, constants and functions of the md5 hash engine
// Holds the microcode program, the step constant table, the rotation amounts
// and the round functions used by the sequencer and the datapath.
// ---------------------------------------------------------------------------
package md5_pkg;

   // widths of the message path
   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 4;
   localparam int unsigned STEP_W = 6;
   localparam int unsigned LEN_W  = 64;
   localparam int unsigned VB_W   = 3;
   localparam int unsigned IDX_W  = 2;
   localparam int unsigned CV_N   = 4;
   localparam int unsigned PC_W   = 4;

   // word positions inside a block
   localparam logic [POS_W-1:0] POS_LAST     = 4'd15;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 4'd14;
   localparam logic [POS_W-1:0] POS_FILL_END = 4'd13;

   localparam logic [STEP_W-1:0] STEP_LAST   = 6'd63;
   localparam logic [VB_W-1:0]   VB_FULL     = 3'd4;
   localparam logic [IDX_W-1:0]  IDX_LAST    = 2'd3;
   localparam logic [WORD_W-1:0] PAD_MARK    = 32'h0000_0080;

   // standard initial chaining value, a first
   localparam logic [WORD_W-1:0] IV_WORDS [0:CV_N-1] = '{
      32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
   };

   // additive constant of each of the 64 steps
   localparam logic [WORD_W-1:0] STEP_CONST [0:63] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotation amount by round and step within the group of four
   localparam logic [4:0] ROT_TABLE [0:15] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // datapath operations, one per microcode step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOAD,
      OP_ROUND,
      OP_ADD,
      OP_PAD,
      OP_FILL,
      OP_LENLO,
      OP_LENHI,
      OP_EMIT,
      OP_INIT
   } md5_op_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_HOLD,
      COND_NOT_FULL,
      COND_FULL,
      COND_NOT_FINAL,
      COND_PAD_DONE,
      COND_POS_LAST,
      COND_LEN_DONE,
      COND_FILL_AGAIN,
      COND_ROUND_MORE,
      COND_EMIT_MORE
   } md5_cond_type;

   // one control word of the program
   typedef struct packed {
      md5_op_type       op;
      md5_cond_type     cond;
      logic [PC_W-1:0]  target;
   } md5_uword_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic hold;
      logic full;
      logic final_msg;
      logic pad_done;
      logic len_done;
      logic pos_last;
      logic fill_again;
      logic round_more;
      logic emit_more;
   } md5_status_type;

   // program addresses
   localparam logic [PC_W-1:0] ADDR_WAIT    = 4'd0;
   localparam logic [PC_W-1:0] ADDR_CHECK   = 4'd1;
   localparam logic [PC_W-1:0] ADDR_LOAD    = 4'd2;
   localparam logic [PC_W-1:0] ADDR_ROUND   = 4'd3;
   localparam logic [PC_W-1:0] ADDR_ADD     = 4'd4;
   localparam logic [PC_W-1:0] ADDR_TAIL    = 4'd5;
   localparam logic [PC_W-1:0] ADDR_PADCHK  = 4'd6;
   localparam logic [PC_W-1:0] ADDR_PAD     = 4'd7;
   localparam logic [PC_W-1:0] ADDR_LENCHK  = 4'd8;
   localparam logic [PC_W-1:0] ADDR_FILL    = 4'd9;
   localparam logic [PC_W-1:0] ADDR_FULLCHK = 4'd10;
   localparam logic [PC_W-1:0] ADDR_LENLO   = 4'd11;
   localparam logic [PC_W-1:0] ADDR_LENHI   = 4'd12;
   localparam logic [PC_W-1:0] ADDR_EMIT    = 4'd13;
   localparam logic [PC_W-1:0] ADDR_INIT    = 4'd14;

   // microcode program
   function automatic md5_uword_type md5_ucode(input logic [PC_W-1:0] pc);
      md5_uword_type w;
      w = '{op: OP_NOP, cond: COND_NONE, target: ADDR_WAIT};
      unique case (pc)
         ADDR_WAIT:    w = '{op: OP_ACCEPT, cond: COND_HOLD,       target: ADDR_WAIT};
         ADDR_CHECK:   w = '{op: OP_NOP,    cond: COND_NOT_FULL,   target: ADDR_TAIL};
         ADDR_LOAD:    w = '{op: OP_LOAD,   cond: COND_NONE,       target: ADDR_WAIT};
         ADDR_ROUND:   w = '{op: OP_ROUND,  cond: COND_ROUND_MORE, target: ADDR_ROUND};
         ADDR_ADD:     w = '{op: OP_ADD,    cond: COND_NONE,       target: ADDR_WAIT};
         ADDR_TAIL:    w = '{op: OP_NOP,    cond: COND_NOT_FINAL,  target: ADDR_WAIT};
         ADDR_PADCHK:  w = '{op: OP_NOP,    cond: COND_PAD_DONE,   target: ADDR_LENCHK};
         ADDR_PAD:     w = '{op: OP_PAD,    cond: COND_POS_LAST,   target: ADDR_LOAD};
         ADDR_LENCHK:  w = '{op: OP_NOP,    cond: COND_LEN_DONE,   target: ADDR_EMIT};
         ADDR_FILL:    w = '{op: OP_FILL,   cond: COND_FILL_AGAIN, target: ADDR_FILL};
         ADDR_FULLCHK: w = '{op: OP_NOP,    cond: COND_FULL,       target: ADDR_LOAD};
         ADDR_LENLO:   w = '{op: OP_LENLO,  cond: COND_NONE,       target: ADDR_WAIT};
         ADDR_LENHI:   w = '{op: OP_LENHI,  cond: COND_ALWAYS,     target: ADDR_LOAD};
         ADDR_EMIT:    w = '{op: OP_EMIT,   cond: COND_EMIT_MORE,  target: ADDR_EMIT};
         ADDR_INIT:    w = '{op: OP_INIT,   cond: COND_ALWAYS,     target: ADDR_WAIT};
         default:      w = '{op: OP_NOP,    cond: COND_ALWAYS,     target: ADDR_WAIT};
      endcase
      return w;
   endfunction

   // round function of each group of sixteen steps
   function automatic logic [WORD_W-1:0] md5_round_fn(
      input logic [1:0]        grp,
      input logic [WORD_W-1:0] b,
      input logic [WORD_W-1:0] c,
      input logic [WORD_W-1:0] d
   );
      logic [WORD_W-1:0] f;
      unique case (grp)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (d & b) | (~d & c);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   // message word index read at a step
   function automatic logic [POS_W-1:0] md5_msg_index(input logic [STEP_W-1:0] step);
      logic [POS_W-1:0] j;
      logic [POS_W-1:0] g;
      j = step[POS_W-1:0];
      unique case (step[STEP_W-1:STEP_W-2])
         2'd0:    g = j;
         2'd1:    g = POS_W'(j * 4'd5 + 4'd1);
         2'd2:    g = POS_W'(j * 4'd3 + 4'd5);
         default: g = POS_W'(j * 4'd7);
      endcase
      return g;
   endfunction

   // rotation amount of a step
   function automatic logic [4:0] md5_rot_amount(input logic [STEP_W-1:0] step);
      return ROT_TABLE[{step[STEP_W-1:STEP_W-2], step[1:0]}];
   endfunction

   // rotate left by a variable amount
   function automatic logic [WORD_W-1:0] md5_rotl(
      input logic [WORD_W-1:0] v,
      input logic [4:0]        s
   );
      logic [2*WORD_W-1:0] x;
      x = {v, v} << s;
      return x[2*WORD_W-1:WORD_W];
   endfunction

endpackage

### design/md5_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_sequencer: microcode sequencer of the md5 hash engine
// Step counter over the program table; each control word selects a datapath
// operation and an optional conditional jump on a datapath flag.
// ---------------------------------------------------------------------------
module md5_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  md5_pkg::md5_status_type status_i,
   output md5_pkg::md5_op_type     op_o
);
   import md5_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   md5_uword_type   uword;
   logic            jump;

   // fetch the control word
   assign uword = md5_ucode(pc_ff);
   assign op_o  = uword.op;

   // evaluate the jump condition
   always_comb begin
      unique case (uword.cond)
         COND_NONE:       jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_HOLD:       jump = status_i.hold;
         COND_NOT_FULL:   jump = !status_i.full;
         COND_FULL:       jump = status_i.full;
         COND_NOT_FINAL:  jump = !status_i.final_msg;
         COND_PAD_DONE:   jump = status_i.pad_done;
         COND_POS_LAST:   jump = status_i.pos_last;
         COND_LEN_DONE:   jump = status_i.len_done;
         COND_FILL_AGAIN: jump = status_i.fill_again;
         COND_ROUND_MORE: jump = status_i.round_more;
         COND_EMIT_MORE:  jump = status_i.emit_more;
         default:         jump = 1'b0;
      endcase
   end

   // next step: jump target or fall through
   assign pc_in = jump ? uword.target : PC_W'(pc_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ADDR_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

### design/md5_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_datapath: message buffer, compression step and digest output
// Carries out the operation chosen by the sequencer each cycle: word intake,
// padding, length words, one compression step, chaining add, digest word output, init.
// ---------------------------------------------------------------------------
module md5_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  md5_pkg::md5_op_type                  op_i,
   output md5_pkg::md5_status_type              status_o,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [md5_pkg::WORD_W-1:0]           req_data_word,
   input  logic [md5_pkg::VB_W-1:0]             req_valid_bytes,
   input  logic                                 req_end_of_message,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [md5_pkg::WORD_W-1:0]           rsp_digest_word,
   output logic [md5_pkg::IDX_W-1:0]            rsp_digest_index,
   output logic                                 rsp_digest_last
);
   import md5_pkg::*;

   // message block storage
   logic [WORD_W-1:0] buf_ff [0:15];
   logic              buf_wr;
   logic [WORD_W-1:0] buf_wr_in;

   // message tracking
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              full_ff, full_in;
   logic              final_ff, final_in;
   logic              pad_done_ff, pad_done_in;
   logic              len_done_ff, len_done_in;
   logic [WORD_W-1:0] pad_word_ff, pad_word_in;

   // compression state
   logic [WORD_W-1:0] chain_ff [0:CV_N-1];
   logic [WORD_W-1:0] chain_in [0:CV_N-1];
   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [WORD_W-1:0] pre_ff, pre_in;
   logic [STEP_W-1:0] rnd_ff, rnd_in;

   // digest output
   logic [IDX_W-1:0]  emit_idx_ff, emit_idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic [IDX_W-1:0]  out_index_ff, out_index_in;
   logic              out_last_ff, out_last_in;

   // intake helpers
   logic              accept;
   logic [VB_W-1:0]   vb_clamp;
   logic [4:0]        byte_shift;
   logic [WORD_W-1:0] keep_mask;
   logic [WORD_W-1:0] pad_word;
   logic [LEN_W-1:0]  len_add;

   // step helpers
   logic [STEP_W-1:0] nxt_step;
   logic [STEP_W-1:0] rd_step;
   logic [WORD_W-1:0] msg_ff;
   logic [WORD_W-1:0] pre_base;
   logic [WORD_W-1:0] pre_sum;
   logic [WORD_W-1:0] f_val;
   logic [WORD_W-1:0] t_val;
   logic [WORD_W-1:0] b_new;

   logic              emit_fire;

   // input handshake
   assign accept    = req_valid && (op_i == OP_ACCEPT);
   assign req_stall = (op_i != OP_ACCEPT);

   // final word: keep valid bytes, append the 0x80 marker
   assign vb_clamp   = (req_valid_bytes > VB_FULL) ? VB_FULL : req_valid_bytes;
   assign byte_shift = {vb_clamp[1:0], 3'b000};
   assign keep_mask  = ~({WORD_W{1'b1}} << byte_shift);
   assign pad_word   = (req_data_word & keep_mask) | (PAD_MARK << byte_shift);
   assign len_add    = req_end_of_message ? LEN_W'({vb_clamp, 3'b000}) : LEN_W'(WORD_W);

   // buffer write selection
   always_comb begin
      buf_wr    = 1'b0;
      buf_wr_in = req_data_word;
      unique case (op_i)
         OP_ACCEPT: buf_wr = accept && (!req_end_of_message || (vb_clamp == VB_FULL));
         OP_PAD: begin
            buf_wr    = 1'b1;
            buf_wr_in = pad_word_ff;
         end
         OP_FILL: begin
            buf_wr    = (pos_ff != POS_LEN_LO);
            buf_wr_in = '0;
         end
         OP_LENLO: begin
            buf_wr    = 1'b1;
            buf_wr_in = len_ff[WORD_W-1:0];
         end
         OP_LENHI: begin
            buf_wr    = 1'b1;
            buf_wr_in = len_ff[LEN_W-1:WORD_W];
         end
         default: ;
      endcase
   end

   // message position, length and phase flags
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      full_in     = full_ff;
      final_in    = final_ff;
      pad_done_in = pad_done_ff;
      len_done_in = len_done_ff;
      pad_word_in = pad_word_ff;
      if (buf_wr) begin
         pos_in = POS_W'(pos_ff + 1'b1);
         if (pos_ff == POS_LAST) begin
            full_in = 1'b1;
         end
      end
      if (accept) begin
         len_in = len_ff + len_add;
         if (req_end_of_message) begin
            final_in    = 1'b1;
            pad_word_in = pad_word;
         end
      end
      if (op_i == OP_ADD) begin
         full_in = 1'b0;
      end
      if (op_i == OP_PAD) begin
         pad_done_in = 1'b1;
      end
      if (op_i == OP_LENHI) begin
         len_done_in = 1'b1;
      end
      if (op_i == OP_INIT) begin
         pos_in      = '0;
         len_in      = '0;
         full_in     = 1'b0;
         final_in    = 1'b0;
         pad_done_in = 1'b0;
         len_done_in = 1'b0;
      end
   end

   // message word read ahead: word 0 before load, step 1 at load, then two steps on
   assign rd_step = (op_i == OP_LOAD)  ? STEP_W'(1) :
                    (op_i == OP_ROUND) ? STEP_W'(rnd_ff + 2'd2) : '0;

   // next step's a + message word + constant, computed one step ahead
   assign nxt_step = (op_i == OP_LOAD) ? '0 : STEP_W'(rnd_ff + 1'b1);
   assign pre_base = (op_i == OP_LOAD) ? chain_ff[0] : d_ff;
   assign pre_sum  = pre_base + msg_ff + STEP_CONST[nxt_step];

   // one compression step
   assign f_val = md5_round_fn(rnd_ff[STEP_W-1:STEP_W-2], b_ff, c_ff, d_ff);
   assign t_val = pre_ff + f_val;
   assign b_new = b_ff + md5_rotl(t_val, md5_rot_amount(rnd_ff));

   // working registers and chaining value
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      pre_in = pre_ff;
      rnd_in = rnd_ff;
      for (int k = 0; k < CV_N; k++) begin
         chain_in[k] = chain_ff[k];
      end
      unique case (op_i)
         OP_LOAD: begin
            a_in   = chain_ff[0];
            b_in   = chain_ff[1];
            c_in   = chain_ff[2];
            d_in   = chain_ff[3];
            pre_in = pre_sum;
            rnd_in = '0;
         end
         OP_ROUND: begin
            a_in   = d_ff;
            d_in   = c_ff;
            c_in   = b_ff;
            b_in   = b_new;
            pre_in = pre_sum;
            rnd_in = STEP_W'(rnd_ff + 1'b1);
         end
         OP_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
         end
         OP_INIT: begin
            for (int k = 0; k < CV_N; k++) begin
               chain_in[k] = IV_WORDS[k];
            end
         end
         default: ;
      endcase
   end

   // digest output register
   assign emit_fire = (op_i == OP_EMIT) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      emit_idx_in  = emit_idx_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_word_in  = chain_ff[emit_idx_ff];
         out_index_in = emit_idx_ff;
         out_last_in  = (emit_idx_ff == IDX_LAST);
         emit_idx_in  = IDX_W'(emit_idx_ff + 1'b1);
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (op_i == OP_INIT) begin
         emit_idx_in = '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_digest_word  = out_word_ff;
   assign rsp_digest_index = out_index_ff;
   assign rsp_digest_last  = out_last_ff;

   // flags for the sequencer
   always_comb begin
      status_o.hold       = !accept || (!req_end_of_message && (pos_ff != POS_LAST));
      status_o.full       = full_ff;
      status_o.final_msg  = final_ff;
      status_o.pad_done   = pad_done_ff;
      status_o.len_done   = len_done_ff;
      status_o.pos_last   = (pos_ff == POS_LAST);
      status_o.fill_again = (pos_ff != POS_FILL_END) && (pos_ff != POS_LEN_LO)
                            && (pos_ff != POS_LAST);
      status_o.round_more = (rnd_ff != STEP_LAST);
      status_o.emit_more  = !(emit_fire && (emit_idx_ff == IDX_LAST));
   end

   // block buffer, registered read
   always_ff @(posedge clock) begin
      if (buf_wr) begin
         buf_ff[pos_ff] <= buf_wr_in;
      end
      msg_ff <= buf_ff[md5_msg_index(rd_step)];
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      pre_ff       <= pre_in;
      pad_word_ff  <= pad_word_in;
      out_word_ff  <= out_word_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   // control registers and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         len_ff       <= '0;
         full_ff      <= 1'b0;
         final_ff     <= 1'b0;
         pad_done_ff  <= 1'b0;
         len_done_ff  <= 1'b0;
         rnd_ff       <= '0;
         emit_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < CV_N; k++) begin
            chain_ff[k] <= IV_WORDS[k];
         end
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         full_ff      <= full_in;
         final_ff     <= final_in;
         pad_done_ff  <= pad_done_in;
         len_done_ff  <= len_done_in;
         rnd_ff       <= rnd_in;
         emit_idx_ff  <= emit_idx_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k < CV_N; k++) begin
            chain_ff[k] <= chain_in[k];
         end
      end
   end

endmodule

### design/md5_hash_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_hash_engine: md5 digest over a stream of 32-bit message words
// Buffers sixteen little-endian words per block, compresses each full block,
// pads the final word and returns the four digest words.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   data_word, valid_bytes, end_of_message
//   rsp      out        rsp_valid/rsp_stall   digest_word, digest_index, digest_last
//
// A word that does not complete a block is taken without holding the input;
// the word that completes a block holds the input while the 64 steps of the
// compression run at one step per cycle, with load, add and program steps
// around them. The final word holds the input through padding fill, one or
// two compressions and four digest words, and while rsp_stall holds output.
// Reset restores the standard initial value and an empty message.
// ---------------------------------------------------------------------------
module md5_hash_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [md5_pkg::WORD_W-1:0]           req_data_word,
   input  logic [md5_pkg::VB_W-1:0]             req_valid_bytes,
   input  logic                                 req_end_of_message,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [md5_pkg::WORD_W-1:0]           rsp_digest_word,
   output logic [md5_pkg::IDX_W-1:0]            rsp_digest_index,
   output logic                                 rsp_digest_last
);
   import md5_pkg::*;

   md5_op_type     op;
   md5_status_type status;

   // program sequencer
   md5_sequencer u_md5_sequencer (
      .clock    (clock),
      .reset    (reset),
      .status_i (status),
      .op_o     (op)
   );

   // message and compression datapath
   md5_datapath u_md5_datapath (
      .clock              (clock),
      .reset              (reset),
      .op_i               (op),
      .status_o           (status),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_digest_index   (rsp_digest_index),
      .rsp_digest_last    (rsp_digest_last)
   );

endmodule

### design/md5_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_checker: port checks of the md5 hash engine
// Watches the request and response ports over time; attached by bind.
// ---------------------------------------------------------------------------
module md5_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [md5_pkg::WORD_W-1:0]           req_data_word,
   input logic [md5_pkg::VB_W-1:0]             req_valid_bytes,
   input logic                                 req_end_of_message,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [md5_pkg::WORD_W-1:0]           rsp_digest_word,
   input logic [md5_pkg::IDX_W-1:0]            rsp_digest_index,
   input logic                                 rsp_digest_last
);
   import md5_pkg::*;

   // a stalled digest word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_digest_index))
      else $error("md5: stalled digest transaction changed");

   // last flag marks exactly the fourth digest word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_digest_index == IDX_LAST)))
      else $error("md5: digest_last does not match digest_index");

   // the final word taken is followed by a stall of the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_message |=> req_stall)
      else $error("md5: input taken right after end of message");

   // while earlier digest words are pending, input stays stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_digest_last |-> req_stall)
      else $error("md5: input taken during digest output");

endmodule

bind md5_hash_engine md5_checker u_md5_checker (.*);
